// File: sv/sgfd_pkg.sv
// ----------------------------------------------------------------------------
// Sphere grid finite difference: shared definitions
// Beat types, register map, status and function codes, parameter defaults.
// ----------------------------------------------------------------------------
package sgfd_pkg;

  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_MAX_COLS    = 128;
  localparam int DEF_SAMPLE_BITS = 32;

  // Function codes of an input beat.
  localparam logic FN_WRITE = 1'b0;
  localparam logic FN_QUERY = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // Register word indexes (byte address = 4 * index).
  localparam logic [1:0] REG_ROWS        = 2'd0;
  localparam logic [1:0] REG_COLS        = 2'd1;
  localparam logic [1:0] REG_THETA_SCALE = 2'd2;
  localparam logic [1:0] REG_PHI_SCALE   = 2'd3;

  localparam logic [6:0]  RST_ROWS  = 7'd64;
  localparam logic [7:0]  RST_COLS  = 8'd128;
  localparam logic [31:0] RST_SCALE = 32'd667544;

  typedef struct packed {
    logic        func;
    logic [5:0]  row;
    logic [6:0]  col;
    logic [31:0] x_value;
    logic [31:0] y_value;
    logic [31:0] z_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] dtheta_x;
    logic [31:0] dtheta_y;
    logic [31:0] dtheta_z;
    logic [31:0] dphi_x;
    logic [31:0] dphi_y;
    logic [31:0] dphi_z;
    logic [1:0]  status;
  } out_item_t;

endpackage

// File: sv/sphere_grid_finite_difference.sv
// ----------------------------------------------------------------------------
// Sphere grid finite difference
// Stores a theta-by-phi grid of xyz samples and returns scaled, saturated
// theta and phi derivatives at a queried point.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries write and query
//   beats. A write beat stores one grid point and gives no result. A query
//   beat reads its four neighbors from the grid memory through one read
//   port, then runs six differences through one shared multiplier that
//   takes 16 bits of the scale at a time, each in steps (low half with
//   rounding, high half with accumulate, saturation). An out-of-range query
//   skips the reads and the differences. in_stall is high while a query is
//   in work; writes go back to back. The result sits in an output register
//   (out_valid, out_stall, out_data); a new beat is accepted while it waits,
//   and a finished query holds its result internally until the register
//   frees up. Reset clears the control state and restores the register
//   defaults; the grid memory is not cleared and a point must be written
//   before it is read. The user must write registers over the APB port
//   only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sphere_grid_finite_difference
  import sgfd_pkg::*;
#(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW    = SAMPLE_BITS;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AWD   = $clog2(CELLS);
  localparam int DW    = SW + 2;        // doubled difference, also its magnitude
  localparam int PW    = DW + 16;       // partial product
  localparam int MW    = PW + 1;        // accumulated magnitude
  localparam logic [MW-1:0] MAXPOS  = {{(MW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic [MW-1:0] MAXNEG  = MAXPOS + MW'(1);
  localparam logic [PW-1:0] RND_HALF = PW'(32'h8000);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_MLO, S_MHI, S_SAT, S_DONE} state_t;

  function automatic logic [SW-1:0] to_sample(logic [31:0] v);
    logic [63:0] w;
    w = {32'b0, v};
    return w[SW-1:0];
  endfunction

  function automatic logic [31:0] to_out(logic [SW-1:0] v);
    logic [63:0] w;
    w = 64'($signed(v));
    return w[31:0];
  endfunction

  // Configuration registers.
  logic [6:0]  rows_in_use;
  logic [7:0]  cols_in_use;
  logic [31:0] theta_scale;
  logic [31:0] phi_scale;

  // Grid memory, one word holds {z, y, x}.
  logic [3*SW-1:0] grid_mem [CELLS];
  logic [3*SW-1:0] rd_data;
  logic [AWD-1:0]  rd_addr;
  logic [AWD-1:0]  wr_addr;
  logic            wr_en;

  state_t          state;
  logic [2:0]      rd_cnt;
  logic [2:0]      dk;
  logic [6:0]      row_q, rhi_q, rlo_q;
  logic [7:0]      col_q, chi_q, clo_q;
  logic            at_edge;
  logic [SW-1:0]   nb [4][3];
  logic [SW-1:0]   res [6];
  logic            sat_any;
  logic [1:0]      status_q;
  logic [PW-1:0]   acc;
  logic [MW-1:0]   mag;

  logic            in_acc;
  logic [6:0]      q_row, last_r;
  logic [7:0]      q_col, last_c;
  logic            q_bad;
  logic [6:0]      sel_row;
  logic [7:0]      sel_col;
  logic [1:0]      comp;
  logic            is_theta;
  logic signed [DW-1:0] d_hi, d_lo, diff;
  logic            neg;
  logic [DW-1:0]   a_mag;
  logic [31:0]     scale;
  logic [15:0]     mul_b;
  logic [PW-1:0]   prod;
  logic            sat_now;
  logic [SW-1:0]   res_now;
  logic            out_free;

  assign pready   = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Query range check and neighbor indexes.
  assign q_row  = {1'b0, in_data.row};
  assign q_col  = {1'b0, in_data.col};
  assign last_r = rows_in_use - 7'd1;
  assign last_c = cols_in_use - 8'd1;
  assign q_bad  = (rows_in_use < 7'd3) || (int'(rows_in_use) > MAX_ROWS) ||
                  (cols_in_use < 8'd3) || (int'(cols_in_use) > MAX_COLS) ||
                  (q_row >= rows_in_use) || (q_col >= cols_in_use);

  assign wr_en   = in_acc && (in_data.func == FN_WRITE) &&
                   (int'(in_data.row) < MAX_ROWS) && (int'(in_data.col) < MAX_COLS);
  assign wr_addr = AWD'(32'(in_data.row) * MAX_COLS + 32'(in_data.col));

  // Neighbor order: row above, row below, column after, column before.
  always_comb begin
    unique case (rd_cnt)
      3'd0:    begin sel_row = rhi_q; sel_col = col_q; end
      3'd1:    begin sel_row = rlo_q; sel_col = col_q; end
      3'd2:    begin sel_row = row_q; sel_col = chi_q; end
      default: begin sel_row = row_q; sel_col = clo_q; end
    endcase
  end
  assign rd_addr = AWD'(32'(sel_row) * MAX_COLS + 32'(sel_col));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= {to_sample(in_data.z_value), to_sample(in_data.y_value),
                            to_sample(in_data.x_value)};
    end
    rd_data <= grid_mem[rd_addr];
  end

  // Shared difference, magnitude and multiplier path.
  assign is_theta = (dk < 3'd3);
  assign comp     = is_theta ? dk[1:0] : 2'(dk - 3'd3);
  always_comb begin
    if (is_theta) begin
      d_hi = DW'($signed(nb[0][comp]));
      d_lo = DW'($signed(nb[1][comp]));
    end else begin
      d_hi = DW'($signed(nb[2][comp]));
      d_lo = DW'($signed(nb[3][comp]));
    end
    diff = d_hi - d_lo;
    // One-sided theta differences at the first and last rows are doubled.
    if (is_theta && at_edge) begin
      diff = diff <<< 1;
    end
  end
  assign neg   = diff[DW-1];
  assign a_mag = neg ? DW'(-diff) : DW'(diff);
  assign scale = is_theta ? theta_scale : phi_scale;
  assign mul_b = (state == S_MLO) ? scale[15:0] : scale[31:16];
  assign prod  = PW'(a_mag) * PW'(mul_b);

  always_comb begin
    if (!neg) begin
      sat_now = (mag > MAXPOS);
      res_now = sat_now ? MAXPOS[SW-1:0] : mag[SW-1:0];
    end else begin
      sat_now = (mag > MAXNEG);
      res_now = sat_now ? MAXNEG[SW-1:0] : SW'(~mag[SW-1:0] + SW'(1));
    end
  end

  // APB register file.
  always_comb begin
    unique case (paddr[3:2])
      REG_ROWS:        prdata = {25'b0, rows_in_use};
      REG_COLS:        prdata = {24'b0, cols_in_use};
      REG_THETA_SCALE: prdata = theta_scale;
      REG_PHI_SCALE:   prdata = phi_scale;
      default:         prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= RST_ROWS;
      cols_in_use <= RST_COLS;
      theta_scale <= RST_SCALE;
      phi_scale   <= RST_SCALE;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_ROWS:        rows_in_use <= pwdata[6:0];
        REG_COLS:        cols_in_use <= pwdata[7:0];
        REG_THETA_SCALE: theta_scale <= pwdata;
        REG_PHI_SCALE:   phi_scale   <= pwdata;
        default:         ;
      endcase
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_cnt    <= 3'd0;
      dk        <= 3'd0;
    end else begin
      // In S_DONE the result register is reloaded instead whenever it frees up.
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && (in_data.func == FN_QUERY)) begin
            row_q <= q_row;
            col_q <= q_col;
            if (q_row == 7'd0) begin
              rhi_q <= 7'd1; rlo_q <= 7'd0; at_edge <= 1'b1;
            end else if (q_row == last_r) begin
              rhi_q <= last_r; rlo_q <= last_r - 7'd1; at_edge <= 1'b1;
            end else begin
              rhi_q <= q_row + 7'd1; rlo_q <= q_row - 7'd1; at_edge <= 1'b0;
            end
            chi_q <= (q_col == last_c) ? 8'd0 : q_col + 8'd1;
            clo_q <= (q_col == 8'd0) ? last_c : q_col - 8'd1;
            rd_cnt  <= 3'd0;
            dk      <= 3'd0;
            sat_any <= 1'b0;
            if (q_bad) begin
              for (int i = 0; i < 6; i++) begin
                res[i] <= '0;
              end
              status_q <= ST_RANGE;
              state    <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // Read data is registered and belongs to the address of the previous count.
          if (rd_cnt != 3'd0) begin
            nb[2'(rd_cnt - 3'd1)][0] <= rd_data[SW-1:0];
            nb[2'(rd_cnt - 3'd1)][1] <= rd_data[2*SW-1:SW];
            nb[2'(rd_cnt - 3'd1)][2] <= rd_data[3*SW-1:2*SW];
          end
          if (rd_cnt == 3'd4) begin
            state <= S_MLO;
          end else begin
            rd_cnt <= rd_cnt + 3'd1;
          end
        end
        S_MLO: begin
          acc   <= (prod + RND_HALF) >> 16;
          state <= S_MHI;
        end
        S_MHI: begin
          mag   <= MW'(prod) + MW'(acc);
          state <= S_SAT;
        end
        S_SAT: begin
          res[dk] <= res_now;
          if (dk == 3'd5) begin
            status_q <= (sat_any || sat_now) ? ST_SAT : ST_OK;
            state    <= S_DONE;
          end else begin
            sat_any <= sat_any || sat_now;
            dk      <= dk + 3'd1;
            state   <= S_MLO;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data.dtheta_x <= to_out(res[0]);
            out_data.dtheta_y <= to_out(res[1]);
            out_data.dtheta_z <= to_out(res[2]);
            out_data.dphi_x   <= to_out(res[3]);
            out_data.dphi_y   <= to_out(res[4]);
            out_data.dphi_z   <= to_out(res[5]);
            out_data.status   <= status_q;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_RANGE) |->
      (out_data.dtheta_x == 32'd0) && (out_data.dphi_z == 32'd0))
    else $error("out-of-range result carries nonzero derivatives");

  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_data.func == FN_QUERY) |=> in_stall)
    else $error("input not held off after a query beat");

  a_read_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (rd_cnt <= 3'd4))
    else $error("neighbor read counter overran");

  a_diff_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_MLO) || (state == S_MHI) || (state == S_SAT) |-> (dk <= 3'd5))
    else $error("difference index overran");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && out_free |=> out_valid && (state == S_IDLE))
    else $error("finished query not moved to the output register");

endmodule

// File: verif/gradient_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sphere grid gradient checker
// Snoops the register port and both beat channels, keeps its own copy of the
// grid and of the register settings, predicts every query result and compares
// the block's results with them in order.
// ----------------------------------------------------------------------------
module gradient_checker
  import sgfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          outstanding,
  output int          points_stored,
  output int          queries_seen,
  output int          range_results,
  output int          clipped_results,
  output int          results_checked
);

  localparam int CELLS = DEF_MAX_ROWS * DEF_MAX_COLS;

  typedef logic signed [31:0] sample_t;

  sample_t     grid_mem [0:2][0:CELLS-1];
  logic [6:0]  rows_cfg;
  logic [7:0]  cols_cfg;
  logic [31:0] theta_cfg;
  logic [31:0] phi_cfg;
  out_item_t   expected_grads [$];

  task automatic report(input string what);
    if (fail_count < 100) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("result %0d %s: got %h, expected %h",
                       results_checked, name, got, want));
    end
  endtask

  function automatic longint stored_sample(input int k, input int unsigned r,
                                           input int unsigned c);
    return longint'(grid_mem[k][r * DEF_MAX_COLS + c]);
  endfunction

  // Q16.16 difference times unsigned Q16.16 scale. The magnitude is rounded
  // half away from zero, then clipped to the signed 32-bit range.
  function automatic logic [31:0] scale_term(input longint diff, input logic [31:0] scale,
                                             output bit clip);
    longint unsigned mag_in;
    longint unsigned mag;
    bit              neg;
    neg = diff < 0;
    mag_in = neg ? -diff : diff;
    mag = mag_in * scale[31:16] + ((mag_in * scale[15:0] + 64'h8000) >> 16);
    clip = 1'b0;
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        clip = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return mag[31:0];
    end
    if (mag > 64'h8000_0000) begin
      clip = 1'b1;
      return 32'h8000_0000;
    end
    return 32'(64'd0 - mag);
  endfunction

  function automatic out_item_t derive_point(input logic [5:0] r, input logic [6:0] c);
    out_item_t   res;
    logic [31:0] d_theta [3];
    logic [31:0] d_phi [3];
    int unsigned last_r, last_c, r_up, r_dn, c_up, c_dn;
    bit          on_edge, clip, any_clip;
    longint      dt, dp;
    res = '0;
    if (rows_cfg < 3 || rows_cfg > DEF_MAX_ROWS || cols_cfg < 3 || cols_cfg > DEF_MAX_COLS
        || r >= rows_cfg || c >= cols_cfg) begin
      res.status = ST_RANGE;
      return res;
    end
    last_r = rows_cfg - 1;
    last_c = cols_cfg - 1;
    on_edge = (r == 0) || (r == last_r);
    if (r == 0) begin
      r_up = 1;
      r_dn = 0;
    end else if (r == last_r) begin
      r_up = last_r;
      r_dn = last_r - 1;
    end else begin
      r_up = r + 1;
      r_dn = r - 1;
    end
    c_up = (c == last_c) ? 0 : c + 1;
    c_dn = (c == 0) ? last_c : c - 1;
    any_clip = 1'b0;
    for (int k = 0; k < 3; k++) begin
      dt = stored_sample(k, r_up, c) - stored_sample(k, r_dn, c);
      dp = stored_sample(k, r, c_up) - stored_sample(k, r, c_dn);
      // The one-sided difference at the first and last row spans one step only.
      if (on_edge) dt = dt * 2;
      d_theta[k] = scale_term(dt, theta_cfg, clip);
      any_clip |= clip;
      d_phi[k] = scale_term(dp, phi_cfg, clip);
      any_clip |= clip;
    end
    res.dtheta_x = d_theta[0];
    res.dtheta_y = d_theta[1];
    res.dtheta_z = d_theta[2];
    res.dphi_x   = d_phi[0];
    res.dphi_y   = d_phi[1];
    res.dphi_z   = d_phi[2];
    res.status   = any_clip ? ST_SAT : ST_OK;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    int        slot;
    if (rst) begin
      rows_cfg = RST_ROWS;
      cols_cfg = RST_COLS;
      theta_cfg = RST_SCALE;
      phi_cfg = RST_SCALE;
      expected_grads.delete();
      fail_count = 0;
      points_stored = 0;
      queries_seen = 0;
      range_results = 0;
      clipped_results = 0;
      results_checked = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ROWS:        rows_cfg = pwdata[6:0];
          REG_COLS:        cols_cfg = pwdata[7:0];
          REG_THETA_SCALE: theta_cfg = pwdata;
          REG_PHI_SCALE:   phi_cfg = pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_data.func == FN_WRITE) begin
          slot = in_data.row * DEF_MAX_COLS + in_data.col;
          grid_mem[0][slot] = in_data.x_value;
          grid_mem[1][slot] = in_data.y_value;
          grid_mem[2][slot] = in_data.z_value;
          points_stored++;
        end else begin
          want = derive_point(in_data.row, in_data.col);
          expected_grads.push_back(want);
          queries_seen++;
          if (want.status == ST_RANGE) range_results++;
          if (want.status == ST_SAT) clipped_results++;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_grads.size() == 0) begin
          report($sformatf("result beat with no query waiting, status %0d",
                           out_data.status));
        end else begin
          want = expected_grads.pop_front();
          compare_field("dtheta_x", out_data.dtheta_x, want.dtheta_x);
          compare_field("dtheta_y", out_data.dtheta_y, want.dtheta_y);
          compare_field("dtheta_z", out_data.dtheta_z, want.dtheta_z);
          compare_field("dphi_x", out_data.dphi_x, want.dphi_x);
          compare_field("dphi_y", out_data.dphi_y, want.dphi_y);
          compare_field("dphi_z", out_data.dphi_z, want.dphi_z);
          compare_field("status", {30'd0, out_data.status}, {30'd0, want.status});
          results_checked++;
        end
      end
    end
    outstanding <= expected_grads.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sphere grid finite difference testbench
// Drives write and query beats with bursty valid and an off, random, patterned
// or heavy result stall, steps through many grid shapes and scale settings over
// the register port, and leaves all checking to the gradient checker.
// ----------------------------------------------------------------------------
module tb_top;
  import sgfd_pkg::*;

  localparam int CELLS         = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_COUNT   = 16;
  localparam int VALID_ITEMS   = 147;
  localparam int RANGE_ITEMS   = 30;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_BURSTY, STALL_HEAVY} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches, grads_due, points_stored, queries_seen;
  int          range_results, clipped_results, results_checked;

  stall_mode_t stall_mode = STALL_NONE;
  logic [3:0]  stall_tick = '0;
  bit          point_written [0:CELLS-1];
  int          cfg_rows = RST_ROWS;
  int          cfg_cols = RST_COLS;
  int          settings_used = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  int          cycle_count = 0;

  always #5 clk = ~clk;

  sphere_grid_finite_difference dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gradient_checker grad_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(mismatches), .outstanding(grads_due),
    .points_stored(points_stored), .queries_seen(queries_seen),
    .range_results(range_results), .clipped_results(clipped_results),
    .results_checked(results_checked)
  );

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_BURSTY: out_stall <= stall_tick[3];
      default:      out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      4, 5, 6:    return $urandom;
      7:          return 32'h7FFF_FFFF;
      8:          return 32'h8000_0000;
      default:    return 32'($urandom_range(0, 8)) - 32'd4;
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 32'h000F_FFFF);
      2:       return RST_SCALE;
      3:       return 32'h0001_0000;
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  function automatic int pick_extent(input int most);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(3, most) : $urandom_range(3, 10);
  endfunction

  function automatic bit grid_valid();
    return cfg_rows >= 3 && cfg_rows <= DEF_MAX_ROWS && cfg_cols >= 3 && cfg_cols <= DEF_MAX_COLS;
  endfunction

  // Holds the beat until it is taken; valid drops only for the gaps between bursts.
  task automatic send_beat(input in_item_t beat);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (grads_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Extent registers get random upper bits; only the low bits are meant to stick.
  task automatic set_grid(input int rows, input int cols, input logic [31:0] theta,
                          input logic [31:0] phi);
    logic [31:0] word;
    drain_results();
    word = $urandom;
    word[6:0] = rows[6:0];
    reg_write(REG_ROWS, word);
    word = $urandom;
    word[7:0] = cols[7:0];
    reg_write(REG_COLS, word);
    reg_write(REG_THETA_SCALE, theta);
    reg_write(REG_PHI_SCALE, phi);
    cfg_rows = rows;
    cfg_cols = cols;
    settings_used++;
  endtask

  task automatic send_write(input int r, input int c, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z);
    in_item_t beat;
    beat.func = FN_WRITE;
    beat.row = 6'(r);
    beat.col = 7'(c);
    beat.x_value = x;
    beat.y_value = y;
    beat.z_value = z;
    point_written[r * DEF_MAX_COLS + c] = 1'b1;
    send_beat(beat);
  endtask

  // Any neighbor that a query would read and that holds no sample yet is
  // written first, so no query ever sees an unwritten point.
  task automatic send_query(input int r, input int c);
    in_item_t beat;
    int       nr [4];
    int       nc [4];
    int       last_r, last_c, r_up, r_dn;
    if (grid_valid() && r < cfg_rows && c < cfg_cols) begin
      last_r = cfg_rows - 1;
      last_c = cfg_cols - 1;
      r_up = (r == 0) ? 1 : (r == last_r) ? last_r : r + 1;
      r_dn = (r == 0) ? 0 : r - 1;
      nr = '{r_up, r_dn, r, r};
      nc = '{c, c, (c == last_c) ? 0 : c + 1, (c == 0) ? last_c : c - 1};
      for (int i = 0; i < 4; i++) begin
        if (!point_written[nr[i] * DEF_MAX_COLS + nc[i]]) begin
          send_write(nr[i], nc[i], rand_sample(), rand_sample(), rand_sample());
        end
      end
    end
    beat.func = FN_QUERY;
    beat.row = 6'(r);
    beat.col = 7'(c);
    beat.x_value = $urandom;
    beat.y_value = $urandom;
    beat.z_value = $urandom;
    send_beat(beat);
  endtask

  task automatic random_item();
    int pick, r, c, span_r, span_c;
    pick = $urandom_range(0, 99);
    span_r = (cfg_rows >= 1 && cfg_rows <= DEF_MAX_ROWS) ? cfg_rows : DEF_MAX_ROWS;
    span_c = (cfg_cols >= 1 && cfg_cols <= DEF_MAX_COLS) ? cfg_cols : DEF_MAX_COLS;
    if (pick < 30) begin
      send_write($urandom_range(0, span_r - 1), $urandom_range(0, span_c - 1),
                 rand_sample(), rand_sample(), rand_sample());
    end else if (pick < 40) begin
      send_write($urandom_range(0, DEF_MAX_ROWS - 1), $urandom_range(0, DEF_MAX_COLS - 1),
                 rand_sample(), rand_sample(), rand_sample());
    end else if (pick < 88) begin
      send_query($urandom_range(0, span_r - 1), $urandom_range(0, span_c - 1));
    end else begin
      if (cfg_rows < DEF_MAX_ROWS && (cfg_cols >= DEF_MAX_COLS || $urandom_range(0, 1))) begin
        r = $urandom_range(cfg_rows, DEF_MAX_ROWS - 1);
        c = $urandom_range(0, DEF_MAX_COLS - 1);
      end else if (cfg_cols < DEF_MAX_COLS) begin
        r = $urandom_range(0, DEF_MAX_ROWS - 1);
        c = $urandom_range(cfg_cols, DEF_MAX_COLS - 1);
      end else begin
        r = $urandom_range(0, DEF_MAX_ROWS - 1);
        c = $urandom_range(0, DEF_MAX_COLS - 1);
      end
      send_query(r, c);
    end
  endtask

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results still due", cycle_count, grads_due);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    stall_mode <= STALL_RANDOM;

    // Reset settings: first and last row, both column wraps, clipped extremes.
    send_write(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_write(1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_query(0, 0);
    send_query(DEF_MAX_ROWS - 1, DEF_MAX_COLS - 1);

    // Smallest grid: exact -2^31 at unit scale, a clip to +max, and a half-step tie.
    set_grid(3, 3, 32'h0001_0000, 32'h0000_8000);
    send_write(0, 0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000);
    send_write(0, 1, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000);
    send_write(0, 2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_write(1, 0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    send_write(1, 1, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000);
    send_write(1, 2, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0000);
    send_write(2, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    send_write(2, 1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h4000_0000);
    send_write(2, 2, 32'h0000_8000, 32'h0000_0000, 32'hC000_0000);
    send_query(1, 0);
    send_query(1, 1);
    send_query(0, 0);
    send_query(2, 2);
    send_query(3, 0);
    send_query(0, 3);
    send_query(DEF_MAX_ROWS - 1, DEF_MAX_COLS - 1);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0:       set_grid(3, 3, 32'hFFFF_FFFF, 32'h0000_0000);
        1:       set_grid(64, 128, 32'h0000_0000, 32'hFFFF_FFFF);
        2:       set_grid(2, 128, pick_scale(), pick_scale());
        3:       set_grid(65, 3, pick_scale(), pick_scale());
        4:       set_grid(5, 2, pick_scale(), pick_scale());
        5:       set_grid(8, 129, pick_scale(), pick_scale());
        6:       set_grid(127, 255, pick_scale(), pick_scale());
        7:       set_grid(0, 0, pick_scale(), pick_scale());
        default: set_grid(pick_extent(DEF_MAX_ROWS), pick_extent(DEF_MAX_COLS),
                          pick_scale(), pick_scale());
      endcase
      // Every fourth phase runs flat out on both sides.
      gaps_on = (ph % 4 != 3);
      stall_mode <= (ph % 4 == 3) ? STALL_NONE : stall_mode_t'($urandom_range(0, 3));
      n = grid_valid() ? VALID_ITEMS : RANGE_ITEMS;
      repeat (n) begin
        random_item();
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end

    drain_results();
    @(negedge clk);
    $display("Covered %0d grid writes and %0d queries (%0d out of range, %0d clipped) over %0d settings.",
             points_stored, queries_seen, range_results, clipped_results, settings_used);
    $display("Compared %0d results, %0d mismatches, %0d still due.",
             results_checked, mismatches, grads_due);
    if (mismatches == 0 && grads_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
